### sv/sorted_table_next_greater_search_defines.svh
// Assertion macros for the sorted table next-greater search block.
`ifndef SORTED_TABLE_NEXT_GREATER_SEARCH_DEFINES_SVH
`define SORTED_TABLE_NEXT_GREATER_SEARCH_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define STGS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the next cycle.
`define STGS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/stgs_pkg.sv
// Package: widths, request kinds and controller/datapath interface types.
package stgs_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int VALUE_W     = 32;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam int REQ_DATA_W  = ((IDX_W + 2 * VALUE_W + 7) / 8) * 8;
   localparam int RSP_FIELD_W = 1 + VALUE_W + CNT_W + 1;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef struct packed {
      logic write;
      logic start;
      logic probe;
      logic load;
   } dp_cmd_type;

   typedef struct packed {
      logic span_empty;
   } dp_status_type;

endpackage

### sv/stgs_datapath.sv
// Datapath: table memory, search bounds, probe compare and result register.
module stgs_datapath import stgs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CNT_W-1:0]      csr_wdata,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic [VALUE_W-1:0] table_mem [TABLE_DEPTH];

   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          n_sat;
   logic [CNT_W-1:0]          lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in, n_ff, n_in;
   logic [CNT_W:0]            mid_sum;
   logic signed [VALUE_W-1:0] key_ff, key_in;
   logic signed [VALUE_W-1:0] rd_data_ff;
   logic [VALUE_W-1:0]        gt_val_ff, gt_val_in;
   logic                      le_eq_ff, le_eq_in;
   logic                      probe_le;
   logic [RSP_DATA_W-1:0]     rsp_data_ff, rsp_data_in;
   logic                      found;
   logic [IDX_W-1:0]          entry_index;
   logic [VALUE_W-1:0]        entry_value;
   logic [VALUE_W-1:0]        search_key;

   assign entry_index = req_tdata[IDX_W-1:0];
   assign entry_value = req_tdata[IDX_W +: VALUE_W];
   assign search_key  = req_tdata[IDX_W + VALUE_W +: VALUE_W];

   assign count_in = csr_we ? csr_wdata : count_ff;
   assign n_sat    = (count_ff > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : count_ff;
   assign probe_le = rd_data_ff <= key_ff;

   always_comb begin
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      n_in      = n_ff;
      key_in    = key_ff;
      gt_val_in = gt_val_ff;
      le_eq_in  = le_eq_ff;
      if (cmd.start) begin
         lo_in     = '0;
         hi_in     = n_sat;
         n_in      = n_sat;
         key_in    = $signed(search_key);
         gt_val_in = '0;
         le_eq_in  = 1'b0;
      end else if (cmd.probe) begin
         if (probe_le) begin
            lo_in    = mid_ff + CNT_W'(1);
            le_eq_in = rd_data_ff == key_ff;
         end else begin
            hi_in     = mid_ff;
            gt_val_in = rd_data_ff;
         end
      end
   end

   assign mid_sum           = {1'b0, lo_in} + {1'b0, hi_in};
   assign mid_in            = mid_sum[CNT_W:1];
   assign status.span_empty = lo_in == hi_in;

   // lo never reaches n unless a greater entry is missing
   assign found = lo_ff != n_ff;

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (cmd.load) begin
         rsp_data_in = RSP_DATA_W'({le_eq_ff & (lo_ff != '0), lo_ff,
                                    found ? gt_val_ff : VALUE_W'(0), found});
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         table_mem[entry_index] <= entry_value;
      end
      rd_data_ff <= $signed(table_mem[mid_in[IDX_W-1:0]]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      n_ff        <= n_in;
      key_ff      <= key_in;
      gt_val_ff   <= gt_val_in;
      le_eq_ff    <= le_eq_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tdata = rsp_data_ff;

endmodule

### sv/stgs_controller.sv
// Controller: search sequencing and result handshake.
module stgs_controller import stgs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic          req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_PROBE = 2'd1;
   localparam logic [1:0] ST_DONE  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_accept;

   assign req_tready = state_ff == ST_IDLE;
   assign req_accept = req_tvalid & req_tready;

   assign cmd.write = req_accept & (req_tuser == REQ_WRITE);
   assign cmd.start = req_accept & (req_tuser == REQ_QUERY);
   assign cmd.probe = state_ff == ST_PROBE;
   assign cmd.load  = (state_ff == ST_DONE) & (~rsp_valid_ff | rsp_tready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.start) begin
               state_in = status.span_empty ? ST_DONE : ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (status.span_empty) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (cmd.load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

### sv/sorted_table_next_greater_search.sv
// Top level: sorted table next-greater search (binary upper bound).
//
//  channel  dir  handshake              payload
//  req      in   req_tvalid/req_tready  tuser: kind; tdata: index, value, key
//  rsp      out  rsp_tvalid/rsp_tready  tdata: found, value, position, present
//  csr      in   csr_we                 csr_wdata: entries_in_use
//
// A query makes k probes, at most 9 for 256 entries, with one table read per
// cycle from the table memory. Reset is synchronous and clears the controller
// and entries_in_use; table contents are undefined until written. A finished
// result waits in the output register; a held rsp stalls the next query only
// in its done state, and write transactions go through while the controller
// is idle.
`include "sorted_table_next_greater_search_defines.svh"

module sorted_table_next_greater_search import stgs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [7:0] entry_index, [39:8] entry_value, [71:40] search_key
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [0] req_type
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] greater_found, [32:1] greater_value, [41:33] greater_position,
   // [42] key_present, [47:43] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CNT_W-1:0]      csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   stgs_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   stgs_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata)
   );

   `STGS_ASSERT_NOW(a_cmd_onehot, clock, reset, 1'b1, $onehot0({cmd.write, cmd.start, cmd.probe, cmd.load}), "more than one datapath command")
   `STGS_ASSERT_NOW(a_load_slot_free, clock, reset, cmd.load, !rsp_tvalid || rsp_tready, "result loaded over a pending one")
   `STGS_ASSERT_NEXT(a_busy_after_query, clock, reset, cmd.start, !req_tready, "request taken during a search")

endmodule
